### src/jdc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the day count to date converter.
package jdc_pkg;

  localparam int unsigned DAY_W  = 32;
  localparam int unsigned JUL_W  = 22;  // every Julian-range count fits in 22 bits
  localparam int unsigned YEAR_W = 24;
  localparam int unsigned DOY_W  = 9;
  localparam int unsigned DOM_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned OFF_W  = 7;   // days into the short 1582 Gregorian tail

  localparam logic [DAY_W-1:0] FIRST_GREG_DAY = 32'd2299161;
  localparam logic [DAY_W-1:0] FIRST_1583_DAY = 32'd2299239;
  localparam logic [DAY_W-1:0] BASE_1201_DAY  = 32'd2159717;

  localparam logic [17:0] GREG_400_DAYS = 18'd146097;
  localparam logic [15:0] GREG_100_DAYS = 16'd36524;
  localparam logic [10:0] JUL_CYCLE_DAYS = 11'd1461;
  localparam logic [10:0] YEAR_DAYS      = 11'd365;
  localparam logic [10:0] LEAP_DAYS      = 11'd366;

  // Reciprocals for constant division: floor(2^32 / 146097), floor(2^22 / 1461)
  localparam logic [14:0] RECIP_400  = 15'd29398;
  localparam logic [11:0] RECIP_1461 = 12'd2870;

  localparam logic [DOY_W-1:0]  OCT15_DOY       = 9'd287;
  localparam logic [YEAR_W-1:0] SWITCH_YEAR     = 24'd1582;
  localparam logic [YEAR_W-1:0] GREG_BASE_YEAR  = 24'd1201;
  localparam logic [12:0]       JUL_EPOCH_YEAR  = 13'd4712;

  typedef enum logic [1:0] {
    PATH_JUL  = 2'd0,
    PATH_MID  = 2'd1,
    PATH_GREG = 2'd2
  } path_t;

  // Sideband that rides along with the divide-by-1461 stages
  typedef struct packed {
    path_t             path;
    logic [OFF_W-1:0]  mid_off;
    logic [YEAR_W-1:0] base_year;
    logic              n100_top;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [JUL_W-1:0] dividend;
  } split_t;

  typedef struct packed {
    tag_t        tag;
    logic [10:0] quot;
    logic [10:0] rem;
  } quot_t;

  // Day of year on which month m (0 = January) starts
  function automatic logic [DOY_W-1:0] month_start(input logic [MON_W-1:0] m,
                                                    input logic leap);
    logic [DOY_W-1:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && (m >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

### src/jdc_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for day counts in and calendar dates out.
interface jdc_day_if import jdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DAY_W-1:0] day_count;

  modport source (output valid, output day_count, input ready);
  modport sink   (input valid, input day_count, output ready);
endinterface

interface jdc_date_if import jdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DOM_W-1:0]  day_of_month;
  logic [MON_W-1:0]  month_number;
  logic [YEAR_W-1:0] year_number;
  logic              before_christ;

  modport source (output valid, output day_of_month, output month_number,
                  output year_number, output before_christ, input ready);
  modport sink   (input valid, input day_of_month, input month_number,
                  input year_number, input before_christ, output ready);
endinterface

### src/julian_day_to_calendar_date.sv
`timescale 1ns / 1ps
// Day count to calendar date converter, ten register stages deep.
// Throughput: one transaction per cycle; the whole pipeline advances together,
// held only while the output register is full and not taken.
// Reset: synchronous rst clears all stage valid bits; data registers are not reset.
module julian_day_to_calendar_date import jdc_pkg::*; (
  input logic         clk,
  input logic         rst,
  jdc_day_if.sink     day_in,
  jdc_date_if.source  date_out
);

  logic   advance;
  logic   split_valid;
  split_t split_data;
  logic   quot_valid;
  quot_t  quot_data;

  // advance when the output register is empty or being drained
  assign advance      = !date_out.valid || date_out.ready;
  assign day_in.ready = advance;

  jdc_cycle_split u_cycle_split (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (day_in.valid),
    .day_count (day_in.day_count),
    .out_valid (split_valid),
    .out_data  (split_data)
  );

  jdc_div1461 u_div1461 (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (split_valid),
    .in_data   (split_data),
    .out_valid (quot_valid),
    .out_data  (quot_data)
  );

  jdc_date_form u_date_form (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (quot_valid),
    .in_data       (quot_data),
    .out_valid     (date_out.valid),
    .day_of_month  (date_out.day_of_month),
    .month_number  (date_out.month_number),
    .year_number   (date_out.year_number),
    .before_christ (date_out.before_christ)
  );

endmodule

### src/jdc_cycle_split.sv
`timescale 1ns / 1ps
// Classifies the day count and splits Gregorian counts into 400 and 100 year cycles.
module jdc_cycle_split import jdc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  logic [DAY_W-1:0] day_count,
  output logic             out_valid,
  output split_t           out_data
);

  typedef struct packed {
    path_t            path;
    logic [OFF_W-1:0] mid_off;
    logic [JUL_W-1:0] jul;
  } side_t;

  // stage A: classify, rebase
  logic             a_valid;
  side_t            a_side;
  logic [DAY_W-1:0] a_diff;
  side_t            a_side_next;

  always_comb begin
    a_side_next.mid_off = OFF_W'(day_count - FIRST_GREG_DAY);
    a_side_next.jul     = day_count[JUL_W-1:0];
    priority if (day_count < FIRST_GREG_DAY) begin
      a_side_next.path = PATH_JUL;
    end else if (day_count < FIRST_1583_DAY) begin
      a_side_next.path = PATH_MID;
    end else begin
      a_side_next.path = PATH_GREG;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_side <= a_side_next;
      a_diff <= day_count - BASE_1201_DAY;
    end
  end

  // stage B: reciprocal estimate of the 400 year quotient
  logic             b_valid;
  side_t            b_side;
  logic [DAY_W-1:0] b_diff;
  logic [14:0]      b_q;
  logic [46:0]      prod_400;

  assign prod_400 = 47'(a_diff) * 47'(RECIP_400);

  always_ff @(posedge clk) begin
    if (advance) begin
      b_side <= a_side;
      b_diff <= a_diff;
      b_q    <= prod_400[46:32];
    end
  end

  // stage C: partial remainder, below twice the cycle length
  logic        c_valid;
  side_t       c_side;
  logic [14:0] c_q;
  logic [18:0] c_rem;

  always_ff @(posedge clk) begin
    if (advance) begin
      c_side <= b_side;
      c_q    <= b_q;
      c_rem  <= 19'(b_diff - 32'(b_q) * 32'(GREG_400_DAYS));
    end
  end

  // stage D: correct the estimate
  logic        d_valid;
  side_t       d_side;
  logic [14:0] d_n400;
  logic [17:0] d_rem;

  always_ff @(posedge clk) begin
    if (advance) begin
      d_side <= c_side;
      if (c_rem >= 19'(GREG_400_DAYS)) begin
        d_n400 <= c_q + 15'd1;
        d_rem  <= 18'(c_rem - 19'(GREG_400_DAYS));
      end else begin
        d_n400 <= c_q;
        d_rem  <= 18'(c_rem);
      end
    end
  end

  // stage E: 100 year cycle, clamped so the last day of 400 years stays in slot 3
  logic [1:0]  n100;
  logic [15:0] rem_100;
  split_t      out_next;

  always_comb begin
    priority if (d_rem >= 18'(3 * GREG_100_DAYS)) begin
      n100 = 2'd3;
    end else if (d_rem >= 18'(2 * GREG_100_DAYS)) begin
      n100 = 2'd2;
    end else if (d_rem >= 18'(GREG_100_DAYS)) begin
      n100 = 2'd1;
    end else begin
      n100 = 2'd0;
    end
    rem_100 = 16'(d_rem - 18'(n100) * 18'(GREG_100_DAYS));

    out_next.tag.path      = d_side.path;
    out_next.tag.mid_off   = d_side.mid_off;
    out_next.tag.n100_top  = (n100 == 2'd3);
    out_next.tag.base_year = GREG_BASE_YEAR + YEAR_W'(d_n400) * YEAR_W'(400)
                             + YEAR_W'(n100) * YEAR_W'(100);
    out_next.dividend      = (d_side.path == PATH_JUL) ? d_side.jul : JUL_W'(rem_100);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      out_valid <= d_valid;
    end
  end

`ifndef ASSERT_OFF
  a_rem_400_corrected: assert property (@(posedge clk) disable iff (rst)
    d_valid && (d_side.path == PATH_GREG) |-> d_rem < GREG_400_DAYS)
    else $error("400 year remainder out of range after correction");
`endif

endmodule

### src/jdc_div1461.sv
`timescale 1ns / 1ps
// Three-stage divide by 1461 (four-year cycle) with reciprocal estimate and correction.
module jdc_div1461 import jdc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  logic   in_valid,
  input  split_t in_data,
  output logic   out_valid,
  output quot_t  out_data
);

  // stage F: quotient estimate, low by at most one
  logic             f_valid;
  tag_t             f_tag;
  logic [JUL_W-1:0] f_x;
  logic [11:0]      f_q;
  logic [33:0]      prod_1461;

  assign prod_1461 = 34'(in_data.dividend) * 34'(RECIP_1461);

  always_ff @(posedge clk) begin
    if (advance) begin
      f_tag <= in_data.tag;
      f_x   <= in_data.dividend;
      f_q   <= prod_1461[33:22];
    end
  end

  // stage G: remainder below twice the cycle length
  logic        g_valid;
  tag_t        g_tag;
  logic [11:0] g_q;
  logic [11:0] g_rem;

  always_ff @(posedge clk) begin
    if (advance) begin
      g_tag <= f_tag;
      g_q   <= f_q;
      g_rem <= 12'(f_x - JUL_W'(f_q) * JUL_W'(JUL_CYCLE_DAYS));
    end
  end

  // stage H: correct
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.tag <= g_tag;
      if (g_rem >= 12'(JUL_CYCLE_DAYS)) begin
        out_data.quot <= 11'(g_q + 12'd1);
        out_data.rem  <= 11'(g_rem - 12'(JUL_CYCLE_DAYS));
      end else begin
        out_data.quot <= 11'(g_q);
        out_data.rem  <= 11'(g_rem);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      g_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      f_valid   <= in_valid;
      g_valid   <= f_valid;
      out_valid <= g_valid;
    end
  end

`ifndef ASSERT_OFF
  a_rem_1461_corrected: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.tag.path != PATH_MID) |-> out_data.rem < JUL_CYCLE_DAYS)
    else $error("four-year remainder out of range after correction");
`endif

endmodule

### src/jdc_date_form.sv
`timescale 1ns / 1ps
// Forms year, era and day of year, then places the day in its month.
module jdc_date_form import jdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  quot_t             in_data,
  output logic              out_valid,
  output logic [DOM_W-1:0]  day_of_month,
  output logic [MON_W-1:0]  month_number,
  output logic [YEAR_W-1:0] year_number,
  output logic              before_christ
);

  // stage I: year and day of year
  logic              i_valid;
  logic [DOY_W-1:0]  i_doy;
  logic              i_leap;
  logic [YEAR_W-1:0] i_year;
  logic              i_bc;

  logic [DOY_W-1:0]  doy_next;
  logic              leap_next;
  logic [YEAR_W-1:0] year_next;
  logic              bc_next;
  logic [1:0]        yr_off;
  logic [10:0]       yr_base;
  logic [12:0]       y4;

  always_comb begin
    doy_next  = '0;
    leap_next = 1'b0;
    year_next = '0;
    bc_next   = 1'b0;
    yr_off    = 2'd0;
    yr_base   = '0;
    y4        = '0;
    unique case (in_data.tag.path)
      PATH_JUL: begin
        // Julian four-year cycle opens with its leap year
        priority if (in_data.rem < LEAP_DAYS) begin
          yr_off  = 2'd0;
          yr_base = '0;
        end else if (in_data.rem < LEAP_DAYS + YEAR_DAYS) begin
          yr_off  = 2'd1;
          yr_base = LEAP_DAYS;
        end else if (in_data.rem < LEAP_DAYS + 2 * YEAR_DAYS) begin
          yr_off  = 2'd2;
          yr_base = LEAP_DAYS + YEAR_DAYS;
        end else begin
          yr_off  = 2'd3;
          yr_base = 11'(LEAP_DAYS + 2 * YEAR_DAYS);
        end
        doy_next  = DOY_W'(in_data.rem - yr_base);
        leap_next = (yr_off == 2'd0);
        y4        = {in_data.quot, 2'b00} + 13'(yr_off);
        if (y4 <= JUL_EPOCH_YEAR) begin
          bc_next   = 1'b1;
          year_next = YEAR_W'(JUL_EPOCH_YEAR + 13'd1 - y4);
        end else begin
          year_next = YEAR_W'(y4 - JUL_EPOCH_YEAR);
        end
      end
      PATH_MID: begin
        doy_next  = OCT15_DOY + DOY_W'(in_data.tag.mid_off);
        year_next = SWITCH_YEAR;
      end
      PATH_GREG: begin
        // Gregorian cycle closes with its leap year; clamp the last day into slot 3
        priority if (in_data.rem >= 3 * YEAR_DAYS) begin
          yr_off = 2'd3;
        end else if (in_data.rem >= 2 * YEAR_DAYS) begin
          yr_off = 2'd2;
        end else if (in_data.rem >= YEAR_DAYS) begin
          yr_off = 2'd1;
        end else begin
          yr_off = 2'd0;
        end
        yr_base   = 11'(11'(yr_off) * YEAR_DAYS);
        doy_next  = DOY_W'(in_data.rem - yr_base);
        leap_next = (yr_off == 2'd3) && ((in_data.quot != 11'd24) || in_data.tag.n100_top);
        year_next = in_data.tag.base_year + YEAR_W'({in_data.quot, 2'b00})
                    + YEAR_W'(yr_off);
      end
      default: begin
        doy_next  = '0;
        year_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      i_doy  <= doy_next;
      i_leap <= leap_next;
      i_year <= year_next;
      i_bc   <= bc_next;
    end
  end

  // stage J: month search over the month start table
  logic [MON_W-1:0] mon_idx;
  logic [DOY_W-1:0] day_idx;

  always_comb begin
    mon_idx = '0;
    for (int m = 1; m < 12; m++) begin
      if (i_doy >= month_start(MON_W'(m), i_leap)) begin
        mon_idx = mon_idx + 4'd1;
      end
    end
    day_idx = i_doy - month_start(mon_idx, i_leap);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      day_of_month  <= DOM_W'(day_idx) + 5'd1;
      month_number  <= mon_idx + 4'd1;
      year_number   <= i_year;
      before_christ <= i_bc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      i_valid   <= in_valid;
      out_valid <= i_valid;
    end
  end

`ifndef ASSERT_OFF
  a_date_fields_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month_number >= 4'd1) && (month_number <= 4'd12)
                  && (day_of_month >= 5'd1) && (year_number != '0))
    else $error("result date fields out of range");

  a_stage_moves_to_output: assert property (@(posedge clk) disable iff (rst)
    i_valid && advance |=> out_valid)
    else $error("valid transaction dropped between last two stages");

  a_bc_only_julian: assert property (@(posedge clk) disable iff (rst)
    i_valid && advance && i_bc |=> before_christ && (year_number <= 24'd4713))
    else $error("BC year out of Julian range");
`endif

endmodule
